>>> hdl/tcw_pkg.sv
// shared types, constants and codes of the text console writer
package tcw_pkg;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELL_COUNT     = COLUMNS * ROWS;
  localparam int LAST_ROW_START = CELL_COUNT - COLUMNS;
  localparam int COL_W          = $clog2(COLUMNS);
  localparam int ROW_W          = $clog2(ROWS);
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } tcw_command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_ATTR  = 1'b0,
    REG_BLANK_ATTR = 1'b1
  } tcw_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } tcw_request_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } tcw_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BS_HIGH,
    ST_READ_WAIT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_PUT,
    CUR_NEWLINE,
    CUR_BACK,
    CUR_HOME
  } tcw_cur_op_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CHAR,
    MEM_BS_LOW,
    MEM_BS_HIGH,
    MEM_READ,
    MEM_COPY_RD,
    MEM_COPY_WR,
    MEM_FILL
  } tcw_mem_op_t;

  typedef enum logic [1:0] {
    SW_HOLD,
    SW_ZERO,
    SW_INC,
    SW_BOTTOM
  } tcw_sweep_op_t;

  typedef struct packed {
    logic          load_req;
    tcw_cur_op_t   cur_op;
    tcw_mem_op_t   mem_op;
    tcw_sweep_op_t sweep_op;
    logic          set_scrolled;
    logic          capture_cell;
    logic          load_result;
  } tcw_cmd_t;

  typedef struct packed {
    tcw_command_t command;
    logic         is_newline;
    logic         is_backspace;
    logic         col_zero;
    logic         col_last;
    logic         row_last;
    logic         copy_last;
    logic         fill_last;
    logic         out_free;
  } tcw_status_t;

endpackage

>>> hdl/tcw_control.sv
// controller state machine of the text console writer
module tcw_control import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        request_valid,
  input  tcw_status_t status,
  output logic        request_stall,
  output tcw_cmd_t    cmd
);

  tcw_state_t state;
  tcw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (request_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.command)
          CMD_PUT: begin
            if (status.is_backspace) begin
              state_next = status.col_zero ? ST_DONE : ST_BS_HIGH;
            end else if ((status.is_newline || status.col_last) && status.row_last) begin
              state_next = ST_COPY_RD;
            end else begin
              state_next = ST_DONE;
            end
          end
          CMD_CLEAR: state_next = ST_FILL;
          CMD_READ:  state_next = ST_READ_WAIT;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_BS_HIGH:   state_next = ST_DONE;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_COPY_RD:   state_next = ST_COPY_WR;
      ST_COPY_WR: begin
        state_next = status.copy_last ? ST_FILL : ST_COPY_RD;
      end
      ST_FILL: begin
        if (status.fill_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request_stall    = (state != ST_IDLE);
    cmd.load_req     = 1'b0;
    cmd.cur_op       = CUR_HOLD;
    cmd.mem_op       = MEM_NONE;
    cmd.sweep_op     = SW_HOLD;
    cmd.set_scrolled = 1'b0;
    cmd.capture_cell = 1'b0;
    cmd.load_result  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.load_req = request_valid;
      end
      ST_EXEC: begin
        case (status.command)
          CMD_PUT: begin
            if (status.is_newline) begin
              cmd.cur_op = CUR_NEWLINE;
            end else if (status.is_backspace) begin
              if (!status.col_zero) begin
                cmd.cur_op = CUR_BACK;
                cmd.mem_op = MEM_BS_LOW;
              end
            end else begin
              cmd.cur_op = CUR_PUT;
              cmd.mem_op = MEM_CHAR;
            end
            if ((status.is_newline || (!status.is_backspace && status.col_last))
                && status.row_last) begin
              cmd.set_scrolled = 1'b1;
              cmd.sweep_op     = SW_ZERO;
            end
          end
          CMD_CLEAR: begin
            cmd.cur_op   = CUR_HOME;
            cmd.sweep_op = SW_ZERO;
          end
          CMD_READ: begin
            cmd.mem_op = MEM_READ;
          end
          default: begin
          end
        endcase
      end
      ST_BS_HIGH: begin
        cmd.mem_op = MEM_BS_HIGH;
      end
      ST_READ_WAIT: begin
        cmd.capture_cell = 1'b1;
      end
      ST_COPY_RD: begin
        cmd.mem_op = MEM_COPY_RD;
      end
      ST_COPY_WR: begin
        cmd.mem_op   = MEM_COPY_WR;
        cmd.sweep_op = status.copy_last ? SW_BOTTOM : SW_INC;
      end
      ST_FILL: begin
        cmd.mem_op   = MEM_FILL;
        cmd.sweep_op = SW_INC;
      end
      ST_DONE: begin
        cmd.load_result = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/tcw_datapath.sv
// cell store, cursor, attribute registers and result register
module tcw_datapath import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]  cfg_data,
  input  tcw_request_t       request,
  input  logic               result_stall,
  input  tcw_cmd_t           cmd,
  output tcw_status_t        status,
  output logic               result_valid,
  output tcw_result_t        result
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata;

  tcw_request_t      req;
  logic [ATTR_W-1:0] text_attr;
  logic [ATTR_W-1:0] blank_attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] sweep;
  logic              scrolled;
  logic [CELL_W-1:0] cell_value;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] wdata;
  logic              in_range;

  assign in_range = ({1'b0, req.cell_index} < (INDEX_W+1)'(CELL_COUNT));

  // register index
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr  <= ATTR_RESET;
      blank_attr <= ATTR_RESET;
    end else if (cfg_write) begin
      case (tcw_reg_t'(cfg_index))
        REG_TEXT_ATTR:  text_attr  <= cfg_data;
        REG_BLANK_ATTR: blank_attr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= request;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = pos;
    raddr  = ADDR_W'(req.cell_index);
    wdata  = {blank_attr, CH_SPACE};
    case (cmd.mem_op)
      MEM_CHAR: begin
        mem_we = 1'b1;
        wdata  = {text_attr, req.char_code};
      end
      MEM_BS_LOW: begin
        mem_we = 1'b1;
        waddr  = pos - ADDR_W'(1);
        wdata  = {text_attr, CH_SPACE};
      end
      MEM_BS_HIGH: begin
        mem_we = 1'b1;
        waddr  = pos + ADDR_W'(1);
        wdata  = {text_attr, CH_SPACE};
      end
      MEM_COPY_RD: begin
        raddr = sweep + ADDR_W'(COLUMNS);
      end
      MEM_COPY_WR: begin
        mem_we = 1'b1;
        waddr  = sweep;
        wdata  = rdata;
      end
      MEM_FILL: begin
        mem_we = 1'b1;
        waddr  = sweep;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // cursor kept both as column/row and as linear position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pos <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_PUT: begin
          if (status.col_last) begin
            col <= '0;
            if (status.row_last) begin
              pos <= ADDR_W'(LAST_ROW_START);
            end else begin
              row <= row + ROW_W'(1);
              pos <= pos + ADDR_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
            pos <= pos + ADDR_W'(1);
          end
        end
        CUR_NEWLINE: begin
          col <= '0;
          if (status.row_last) begin
            pos <= ADDR_W'(LAST_ROW_START);
          end else begin
            row <= row + ROW_W'(1);
            pos <= pos - ADDR_W'(col) + ADDR_W'(COLUMNS);
          end
        end
        CUR_BACK: begin
          col <= col - COL_W'(1);
          pos <= pos - ADDR_W'(1);
        end
        CUR_HOME: begin
          col <= '0;
          row <= '0;
          pos <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.sweep_op)
      SW_ZERO:   sweep <= '0;
      SW_INC:    sweep <= sweep + ADDR_W'(1);
      SW_BOTTOM: sweep <= ADDR_W'(LAST_ROW_START);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      scrolled   <= 1'b0;
      cell_value <= '0;
    end else begin
      if (cmd.set_scrolled) begin
        scrolled <= 1'b1;
      end
      if (cmd.capture_cell) begin
        cell_value <= in_range ? rdata : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result.cursor_position <= POS_W'(pos);
      result.cell_value      <= cell_value;
      result.scrolled        <= scrolled;
    end
  end

  always_comb begin
    status.command      = tcw_command_t'(req.command);
    status.is_newline   = (req.char_code == CH_NEWLINE);
    status.is_backspace = (req.char_code == CH_BACKSPACE);
    status.col_zero     = (col == '0);
    status.col_last     = (col == COL_W'(COLUMNS - 1));
    status.row_last     = (row == ROW_W'(ROWS - 1));
    status.copy_last    = (sweep == ADDR_W'(LAST_ROW_START - 1));
    status.fill_last    = (sweep == ADDR_W'(CELL_COUNT - 1));
    status.out_free     = !result_valid || !result_stall;
  end

endmodule

>>> hdl/text_console_writer.sv
// top level of the text console writer
// A text console holding COLUMNS x ROWS cells of attribute and character,
// plus a cursor. Requests arrive on request/request_valid and are taken
// when request_stall is low; one request is handled at a time. Each
// request gives exactly one result on result/result_valid, held until a
// cycle with result_stall low.
// Put, newline and unused commands go from execute straight to done; a read
// passes a wait state for the store data, and a backspace off column zero
// blanks a second cell in its own state. A newline on the last row, or a put
// into its last column, scrolls: the row copy uses the single store port for
// a read and a write per cell, then the last row is blanked. Clear writes one
// cell a cycle. The next request is taken the cycle after the result is loaded.
// If the receiver stalls, the result waits in the output register; the next
// result holds in the done state until the output register is free.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at
// once and belong only in idle periods.
// Reset clears the cursor, result_valid and sets both attributes to 7;
// cell contents are unknown until written by put, backspace, scroll or
// clear, so clear the screen before reading.
module text_console_writer import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ATTR_W-1:0]    cfg_data,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  tcw_request_t         request,
  output logic                 result_valid,
  input  logic                 result_stall,
  output tcw_result_t          result
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_control u_control (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .status        (status),
    .request_stall (request_stall),
    .cmd           (cmd)
  );

  tcw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .request      (request),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the text console writer with its own console predictor
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_ITEMS   = 170;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ATTR_W-1:0]    cfg_data = '0;
  logic                 request_valid = 1'b0;
  logic                 request_stall;
  tcw_request_t         request = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  tcw_result_t          result;

  // console predictor state
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int                cur_col = 0;
  int                cur_row = 0;
  logic [ATTR_W-1:0] text_attr_model = ATTR_RESET;
  logic [ATTR_W-1:0] blank_attr_model = ATTR_RESET;

  tcw_result_t due_results [$];
  tcw_result_t oldest;
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  text_console_writer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always #5 clk = ~clk;

  function automatic logic console_new_line();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) return 1'b0;
    cur_row = ROWS - 1;
    for (i = 0; i < LAST_ROW_START; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (i = LAST_ROW_START; i < CELL_COUNT; i++) screen_model[i] = {blank_attr_model, CH_SPACE};
    return 1'b1;
  endfunction

  // applies one request to the predictor and returns the result it should give
  function automatic tcw_result_t advance_console(tcw_request_t req);
    tcw_result_t res;
    int pos;
    res = '0;
    case (tcw_command_t'(req.command))
      CMD_PUT: begin
        if (req.char_code == CH_NEWLINE) begin
          res.scrolled = console_new_line();
        end else if (req.char_code == CH_BACKSPACE) begin
          if (cur_col != 0) begin
            cur_col--;
            pos = cur_row * COLUMNS + cur_col;
            screen_model[pos] = {text_attr_model, CH_SPACE};
            screen_model[pos + 1] = {text_attr_model, CH_SPACE};
          end
        end else begin
          screen_model[cur_row * COLUMNS + cur_col] = {text_attr_model, req.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) res.scrolled = console_new_line();
        end
      end
      CMD_CLEAR: begin
        for (pos = 0; pos < CELL_COUNT; pos++) screen_model[pos] = {blank_attr_model, CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        if (req.cell_index < CELL_COUNT) res.cell_value = screen_model[req.cell_index];
      end
      default: ;
    endcase
    res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  function automatic tcw_request_t req_of(tcw_command_t cmd, logic [CHAR_W-1:0] ch,
                                          logic [INDEX_W-1:0] idx);
    tcw_request_t req;
    req.command = cmd;
    req.char_code = ch;
    req.cell_index = idx;
    return req;
  endfunction

  function automatic logic [CHAR_W-1:0] printable_char();
    logic [CHAR_W-1:0] ch;
    ch = CHAR_W'($urandom_range(255));
    while (ch == CH_NEWLINE || ch == CH_BACKSPACE) ch = CHAR_W'($urandom_range(255));
    return ch;
  endfunction

  // mostly text with line breaks, so the cursor reaches the bottom row and scrolls
  function automatic tcw_request_t random_request();
    int pick;
    logic [CHAR_W-1:0] ch;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(199);
    ch = CHAR_W'($urandom_range(255));
    idx = INDEX_W'($urandom_range(2047));
    if (pick < 110) return req_of(CMD_PUT, ch, idx);
    if (pick < 140) return req_of(CMD_PUT, CH_NEWLINE, idx);
    if (pick < 160) return req_of(CMD_PUT, CH_BACKSPACE, idx);
    if (pick < 193) begin
      if ($urandom_range(9) != 0) idx = INDEX_W'($urandom_range(CELL_COUNT - 1));
      return req_of(CMD_READ, ch, idx);
    end
    if (pick < 194) return req_of(CMD_CLEAR, ch, idx);
    return req_of(CMD_NONE, ch, idx);
  endfunction

  task automatic send_request(input tcw_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request <= req;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    due_results.push_back(advance_console(req));
  endtask

  task automatic finish_phase();
    request_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [ATTR_W-1:0] text_attr,
                           input logic [ATTR_W-1:0] blank_attr);
    cfg_write <= 1'b1;
    cfg_index <= REG_TEXT_ATTR;
    cfg_data <= text_attr;
    @(posedge clk);
    cfg_index <= REG_BLANK_ATTR;
    cfg_data <= blank_attr;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    text_attr_model = text_attr;
    blank_attr_model = blank_attr;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct = sender;
    stall_pct = receiver;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_request(random_request());
  endtask

  task automatic test_directed();
    send_request(req_of(CMD_READ, 8'h00, 11'd2047));
    send_request(req_of(CMD_READ, 8'hFF, 11'd2000));
    send_request(req_of(CMD_NONE, 8'hFF, 11'h7FF));
    send_request(req_of(CMD_CLEAR, 8'h00, 11'd0));
    send_request(req_of(CMD_PUT, 8'h00, 11'd0));
    send_request(req_of(CMD_PUT, 8'hFF, 11'd0));
    send_request(req_of(CMD_PUT, 8'h41, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'd1));
    send_request(req_of(CMD_READ, 8'h00, 11'd2));
    send_request(req_of(CMD_PUT, CH_BACKSPACE, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'd2));
    send_request(req_of(CMD_READ, 8'h00, 11'd3));
    send_request(req_of(CMD_PUT, CH_NEWLINE, 11'd0));
    send_request(req_of(CMD_PUT, CH_BACKSPACE, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'd1999));
    send_request(req_of(CMD_READ, 8'h00, 11'd0));
    send_request(req_of(CMD_NONE, 8'h00, 11'd0));
    finish_phase();
  endtask

  task automatic test_scroll();
    configure(8'h00, 8'hFF);
    send_request(req_of(CMD_CLEAR, 8'h00, 11'd0));
    repeat (ROWS) send_request(req_of(CMD_PUT, CH_NEWLINE, 11'd0));
    repeat (COLUMNS) send_request(req_of(CMD_PUT, printable_char(), 11'd0));
    send_request(req_of(CMD_PUT, CH_BACKSPACE, 11'd0));
    repeat (3) send_request(req_of(CMD_PUT, printable_char(), 11'd0));
    send_request(req_of(CMD_PUT, CH_BACKSPACE, 11'd0));
    send_request(req_of(CMD_PUT, CH_NEWLINE, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'(LAST_ROW_START - 1)));
    send_request(req_of(CMD_READ, 8'h00, 11'(LAST_ROW_START)));
    send_request(req_of(CMD_READ, 8'h00, 11'(CELL_COUNT - 1)));
    send_request(req_of(CMD_READ, 8'h00, 11'(LAST_ROW_START - COLUMNS)));
    finish_phase();
    configure(8'hFF, 8'h00);
    send_request(req_of(CMD_CLEAR, 8'h00, 11'd0));
    send_request(req_of(CMD_PUT, printable_char(), 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'd0));
    send_request(req_of(CMD_READ, 8'h00, 11'(CELL_COUNT - 1)));
    finish_phase();
  endtask

  task automatic test_random_idling();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      configure(CHAR_W'($urandom_range(255)), CHAR_W'($urandom_range(255)));
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(83, 0);
        2: set_idling(0, 83);
        default: set_idling(30, 30);
      endcase
      run_random(PHASE_ITEMS);
      finish_phase();
    end
  endtask

  task automatic test_pressure();
    set_idling(0, 0);
    hold_seq++;
    run_random(30);
    finish_phase();
    run_random(10);
    finish_phase();
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none due, actual %h", $time, result);
        errors++;
      end else begin
        oldest = due_results.pop_front();
        if (result.cursor_position !== oldest.cursor_position) begin
          $display("%0t: cursor_position expected %0d actual %0d", $time,
                   oldest.cursor_position, result.cursor_position);
          errors++;
        end
        if (result.cell_value !== oldest.cell_value) begin
          $display("%0t: cell_value expected %h actual %h", $time,
                   oldest.cell_value, result.cell_value);
          errors++;
        end
        if (result.scrolled !== oldest.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time,
                   oldest.scrolled, result.scrolled);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_scroll();
    test_random_idling();
    test_pressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/tcw_pkg.sv
hdl/tcw_control.sv
hdl/tcw_datapath.sv
hdl/text_console_writer.sv
tb/tb_top.sv
